// ===== design/round_robin_slice_dispatcher_core_macros.svh =====
// Assertion helpers for the dispatcher core.
`ifndef ROUND_ROBIN_SLICE_DISPATCHER_CORE_MACROS_SVH
`define ROUND_ROBIN_SLICE_DISPATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rrsd_pkg.sv =====
package rrsd_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned CLOCK_W = 32;
  localparam int unsigned STAT_W  = 3;

  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [ID_W-1:0]    job_id_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;
  typedef logic [CLOCK_W-1:0] clock_t;

  localparam status_t STATUS_ADMITTED = 3'd0;
  localparam status_t STATUS_RAN      = 3'd1;
  localparam status_t STATUS_FULL     = 3'd2;
  localparam status_t STATUS_EMPTY    = 3'd3;
  localparam status_t STATUS_DROPPED  = 3'd4;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_TIME_QUANTUM   = 1'd0;
  localparam cfg_index_t REG_CONTEXT_SWITCH = 1'd1;

  localparam cfg_word_t QUANTUM_RESET = 16'd4;
  localparam cfg_word_t SWITCH_RESET  = 16'd1;

  localparam logic MODE_ADMIT    = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

endpackage

// ===== design/rrsd_in_if.sv =====
interface rrsd_in_if;
  import rrsd_pkg::*;

  logic     valid;
  logic     ready;
  logic     mode;
  logic [BURST_W-1:0] burst_time;

  modport source (output valid, output mode, output burst_time, input ready);
  modport sink   (input valid, input mode, input burst_time, output ready);
endinterface

// ===== design/rrsd_out_if.sv =====
interface rrsd_out_if;
  import rrsd_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  job_id_t job_id;
  logic [CFG_W-1:0] slice_length;
  clock_t  slice_start;
  clock_t  clock_after;
  logic    job_finished;

  modport source (output valid, output status, output job_id, output slice_length,
                  output slice_start, output clock_after, output job_finished,
                  input ready);
  modport sink   (input valid, input status, input job_id, input slice_length,
                  input slice_start, input clock_after, input job_finished,
                  output ready);
endinterface

// ===== design/rrsd_queue.sv =====
module rrsd_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write; the caller bypasses a colliding write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/round_robin_slice_dispatcher_core.sv =====
// Round-robin slice dispatcher. Each beat on in_ch either admits a job (mode 0) with
// burst_time units of service, or dispatches one slice from the head of the job queue
// (mode 1); exactly one result beat follows on out_ch, in the cycle after acceptance.
// One item is taken per cycle while in_ch.ready is high: ready is high whenever the output
// register is empty or being drained, so a full, stalled output register holds the input off.
// Jobs wait in a QUEUE_DEPTH-entry RAM with one write and one registered read port;
// the head entry is read ahead via head_index_next and a write landing on the next head is
// bypassed, so there is no clearing pass after reset. Remaining times are TIME_WIDTH
// bits wide and admitted bursts saturate to that width. Write time_quantum (index 0)
// and context_switch_time (index 1) only while no beat is in flight.
module round_robin_slice_dispatcher_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  rrsd_in_if.sink                in_ch,
  rrsd_out_if.source             out_ch,
  input  logic                   cfg_write,
  input  rrsd_pkg::cfg_index_t   cfg_index,
  input  rrsd_pkg::cfg_word_t    cfg_data
);
  import rrsd_pkg::*;
  `include "round_robin_slice_dispatcher_core_macros.svh"

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam int unsigned ENT_W = ID_W + TIME_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef logic [TIME_WIDTH-1:0] rem_t;
  typedef struct packed {
    job_id_t id;
    rem_t    rem;
  } job_t;

  cfg_word_t        time_quantum;
  cfg_word_t        context_switch_time;
  logic [IDX_W-1:0] head_index, head_index_next;
  logic [IDX_W-1:0] tail_index, tail_index_next;
  logic [CNT_W-1:0] queue_count, queue_count_next;
  job_id_t          next_identifier;
  clock_t           clock_now, clock_now_next;
  logic             byp_valid;
  job_t             byp_job;
  job_t             rd_job;
  job_t             head_job;

  logic             accept;
  logic             admit_ok, pop, requeue, wr_en;
  job_t             wr_job;
  rem_t             burst_sat;
  logic [CMP_W-1:0] slice_w;
  rem_t             rem_left;
  logic             head_zero;

  status_t          status_d;
  job_id_t          job_id_d;
  logic [CFG_W-1:0] slice_d;
  logic             finished_d;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign head_job  = byp_valid ? byp_job : rd_job;
  assign head_zero = (head_job.rem == '0);

  assign burst_sat = (CMP_W'(in_ch.burst_time) > CMP_W'(TIME_MAX)) ?
                     TIME_MAX : TIME_WIDTH'(in_ch.burst_time);

  assign slice_w  = (CMP_W'(time_quantum) < CMP_W'(head_job.rem)) ?
                    CMP_W'(time_quantum) : CMP_W'(head_job.rem);
  assign rem_left = TIME_WIDTH'(CMP_W'(head_job.rem) - slice_w);

  assign admit_ok = accept && (in_ch.mode == MODE_ADMIT) && (queue_count != FULL_CNT);
  assign pop      = accept && (in_ch.mode == MODE_DISPATCH) && (queue_count != '0);
  assign requeue  = pop && !head_zero && (rem_left != '0);
  assign wr_en    = admit_ok || requeue;
  assign wr_job   = admit_ok ? job_t'{id: next_identifier, rem: burst_sat}
                             : job_t'{id: head_job.id, rem: rem_left};

  always_comb begin
    head_index_next  = pop ? wrap_next(head_index) : head_index;
    tail_index_next  = wr_en ? wrap_next(tail_index) : tail_index;
    queue_count_next = queue_count + CNT_W'(wr_en) - CNT_W'(pop);
    clock_now_next   = clock_now;
    if (pop && !head_zero) begin
      clock_now_next = clock_now + CLOCK_W'(slice_w[CFG_W-1:0])
                       + CLOCK_W'(context_switch_time);
    end
  end

  always_comb begin
    status_d   = STATUS_EMPTY;
    job_id_d   = '0;
    slice_d    = '0;
    finished_d = 1'b0;
    if (in_ch.mode == MODE_ADMIT) begin
      if (queue_count == FULL_CNT) begin
        status_d = STATUS_FULL;
      end else begin
        status_d = STATUS_ADMITTED;
        job_id_d = next_identifier;
      end
    end else if (queue_count != '0) begin
      job_id_d = head_job.id;
      if (head_zero) begin
        status_d   = STATUS_DROPPED;
        finished_d = 1'b1;
      end else begin
        status_d   = STATUS_RAN;
        slice_d    = slice_w[CFG_W-1:0];
        finished_d = (rem_left == '0);
      end
    end
  end

  rrsd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_index),
    .wr_data (wr_job),
    .rd_addr (head_index_next),
    .rd_data (rd_job)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum        <= QUANTUM_RESET;
      context_switch_time <= SWITCH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_QUANTUM:   time_quantum        <= cfg_data;
        REG_CONTEXT_SWITCH: context_switch_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index      <= '0;
      tail_index      <= '0;
      queue_count     <= '0;
      next_identifier <= '0;
      clock_now       <= '0;
      byp_valid       <= 1'b0;
      out_ch.valid    <= 1'b0;
    end else begin
      head_index  <= head_index_next;
      tail_index  <= tail_index_next;
      queue_count <= queue_count_next;
      clock_now   <= clock_now_next;
      if (admit_ok) begin
        next_identifier <= next_identifier + 1'b1;
      end
      // hold the written entry when it becomes the next head
      byp_valid <= wr_en && (tail_index == head_index_next);
      if (accept) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_job <= wr_job;
    if (accept) begin
      out_ch.status       <= status_d;
      out_ch.job_id       <= job_id_d;
      out_ch.slice_length <= slice_d;
      out_ch.slice_start  <= clock_now;
      out_ch.clock_after  <= clock_now_next;
      out_ch.job_finished <= finished_d;
    end
  end

  `RRSD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, queue_count <= FULL_CNT,
    "queue count above depth")
  `RRSD_ASSERT_NOW(a_empty_aligned, clk, rst, queue_count == '0, head_index == tail_index,
    "empty queue with head and tail apart")
  `RRSD_ASSERT_NOW(a_full_report, clk, rst,
    out_ch.valid && (out_ch.status == STATUS_FULL), queue_count == FULL_CNT,
    "full reported while queue has room")
  `RRSD_ASSERT_NOW(a_empty_report, clk, rst,
    out_ch.valid && (out_ch.status == STATUS_EMPTY), queue_count == '0,
    "empty reported while queue holds jobs")
  `RRSD_ASSERT_NEXT(a_admit_grows, clk, rst, admit_ok,
    queue_count == $past(queue_count) + 1'b1, "admitted job not counted")

endmodule

// ===== sim/tb.sv =====
module tb;
  import rrsd_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_WIDTH  = 16;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 115;

  typedef struct packed {
    status_t          status;
    job_id_t          job_id;
    logic [CFG_W-1:0] slice_length;
    clock_t           slice_start;
    clock_t           clock_after;
    logic             job_finished;
  } slice_result_t;

  class slice_scoreboard;
    job_id_t          job_ids[QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] job_remaining[QUEUE_DEPTH];
    int               head;
    int               tail;
    int               count;
    job_id_t          next_id;
    clock_t           now;
    cfg_word_t        quantum;
    cfg_word_t        switch_cost;
    slice_result_t    expected_results[$];
    int               errors;

    function new();
      head        = 0;
      tail        = 0;
      count       = 0;
      next_id     = '0;
      now         = '0;
      quantum     = QUANTUM_RESET;
      switch_cost = SWITCH_RESET;
      errors      = 0;
    endfunction

    function void set_reg(cfg_index_t idx, cfg_word_t value);
      if (idx == REG_TIME_QUANTUM) quantum = value;
      else if (idx == REG_CONTEXT_SWITCH) switch_cost = value;
    endfunction

    function void enqueue_job(job_id_t id, logic [TIME_WIDTH-1:0] remaining);
      job_ids[tail]       = id;
      job_remaining[tail] = remaining;
      tail                = (tail + 1) % QUEUE_DEPTH;
      count++;
    endfunction

    // Work out the result of one accepted beat and advance the queue and clock.
    function void note_item(logic mode, logic [BURST_W-1:0] burst);
      slice_result_t         r;
      logic [TIME_WIDTH-1:0] remaining;
      r.status       = STATUS_ADMITTED;
      r.job_id       = '0;
      r.slice_length = '0;
      r.slice_start  = now;
      r.clock_after  = now;
      r.job_finished = 1'b0;
      if (mode == MODE_ADMIT) begin
        if (count >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          r.job_id = next_id;
          enqueue_job(next_id, burst);
          next_id++;
        end
      end else if (count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.job_id  = job_ids[head];
        remaining = job_remaining[head];
        head      = (head + 1) % QUEUE_DEPTH;
        count--;
        if (remaining == 0) begin
          r.status       = STATUS_DROPPED;
          r.job_finished = 1'b1;
        end else begin
          r.status       = STATUS_RAN;
          r.slice_length = (quantum < remaining) ? quantum : remaining;
          remaining      = remaining - r.slice_length;
          now            = now + r.slice_length + switch_cost;
          r.clock_after  = now;
          if (remaining != 0) enqueue_job(r.job_id, remaining);
          else r.job_finished = 1'b1;
        end
      end
      expected_results = {expected_results, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(slice_result_t got);
      slice_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected beat status %0d id %0d", got.status, got.job_id));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.job_id !== want.job_id)
        report($sformatf("job_id %0d, want %0d", got.job_id, want.job_id));
      if (got.slice_length !== want.slice_length)
        report($sformatf("slice_length %0d, want %0d", got.slice_length, want.slice_length));
      if (got.slice_start !== want.slice_start)
        report($sformatf("slice_start %0d, want %0d", got.slice_start, want.slice_start));
      if (got.clock_after !== want.clock_after)
        report($sformatf("clock_after %0d, want %0d", got.clock_after, want.clock_after));
      if (got.job_finished !== want.job_finished)
        report($sformatf("job_finished %0b, want %0b", got.job_finished, want.job_finished));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  cfg_index_t cfg_index;
  cfg_word_t  cfg_data;

  rrsd_in_if  in_if();
  rrsd_out_if out_if();

  round_robin_slice_dispatcher_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slice_scoreboard sb = new();
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int long_hold_reqs     = 0;
  int hold_served        = 0;
  int hold_left          = 0;
  int stall_cycles       = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [BURST_W-1:0] draw_burst();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 60) return BURST_W'($urandom_range(1, 12));
    if (r < 80) return BURST_W'($urandom_range(1, 300));
    return BURST_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(input logic mode, input logic [BURST_W-1:0] burst);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.burst_time <= burst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(mode, burst);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the quantum register, then the context-switch register; the enable drops after.
  task automatic write_regs(input cfg_word_t quantum, input cfg_word_t switch_cost);
    cfg_write <= 1'b1;
    cfg_index <= REG_TIME_QUANTUM;
    cfg_data  <= quantum;
    @(posedge clk);
    sb.set_reg(REG_TIME_QUANTUM, quantum);
    cfg_index <= REG_CONTEXT_SWITCH;
    cfg_data  <= switch_cost;
    @(posedge clk);
    sb.set_reg(REG_CONTEXT_SWITCH, switch_cost);
    cfg_write <= 1'b0;
  endtask

  // Sink side: check each result beat, then choose the next ready.
  always @(posedge clk) begin
    slice_result_t got;
    if (!rst && out_if.valid && out_if.ready) begin
      got.status       = out_if.status;
      got.job_id       = out_if.job_id;
      got.slice_length = out_if.slice_length;
      got.slice_start  = out_if.slice_start;
      got.clock_after  = out_if.clock_after;
      got.job_finished = out_if.job_finished;
      sb.check_result(got);
    end
    if (hold_served != long_hold_reqs) begin
      hold_served = long_hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int        phase;
    int        n;
    int        admit_pct;
    logic      mode;
    cfg_word_t quantum;
    cfg_word_t switch_cost;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_TIME_QUANTUM;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_ADMIT;
    in_if.burst_time = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_regs(QUANTUM_RESET, SWITCH_RESET);
    // Empty queue, zero and largest bursts, a drop, a partial and a finishing slice.
    send_item(MODE_DISPATCH, '1);
    send_item(MODE_ADMIT, '0);
    send_item(MODE_ADMIT, '1);
    send_item(MODE_ADMIT, 16'd1);
    send_item(MODE_ADMIT, 16'd5);
    repeat (4) send_item(MODE_DISPATCH, BURST_W'($urandom_range(0, 65535)));
    // Fill the queue, then one admit past full.
    repeat (QUEUE_DEPTH - 2) send_item(MODE_ADMIT, draw_burst());
    send_item(MODE_ADMIT, 16'd7);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
      case (phase)
        0: begin quantum = QUANTUM_RESET; switch_cost = SWITCH_RESET; end
        1: begin quantum = 16'd1; switch_cost = 16'd0; end
        2: begin quantum = '1; switch_cost = '1; end
        3: begin
          quantum     = cfg_word_t'($urandom_range(1, 8));
          switch_cost = cfg_word_t'($urandom_range(0, 65535));
        end
        // zero quantum: slices of nothing, jobs requeued as they were
        4: begin quantum = '0; switch_cost = 16'd3; end
        5: begin
          quantum     = cfg_word_t'($urandom_range(1, 65535));
          switch_cost = cfg_word_t'($urandom_range(0, 65535));
        end
        6: begin quantum = 16'd2; switch_cost = '1; end
        default: begin
          quantum     = cfg_word_t'($urandom_range(1, 30));
          switch_cost = cfg_word_t'($urandom_range(0, 10));
        end
      endcase
      write_regs(quantum, switch_cost);
      admit_pct = $urandom_range(35, 65);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sink off while beats keep coming, so the input backs up
        if (phase == 0 && n == 40) long_hold_reqs <= long_hold_reqs + 1;
        if (phase == 5 && n == 60) wait_drained();
        mode = ($urandom_range(99) < admit_pct) ? MODE_ADMIT : MODE_DISPATCH;
        send_item(mode, draw_burst());
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    while (sb.expected_results.size() != 0) begin
      void'(sb.expected_results.pop_front());
      sb.report("result never arrived");
    end
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
